// ===== sv/mod_matrix2_power_core_defines.svh =====
// ----------------------------------------------------------------------------
// mod_matrix2_power_core_defines
// Assertion macros used by the checker file of the matrix power block.
// ----------------------------------------------------------------------------
`ifndef MOD_MATRIX2_POWER_CORE_DEFINES_SVH
`define MOD_MATRIX2_POWER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MM2P_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mm2p assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MM2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mm2p assertion failed");

`endif

// ===== sv/mm2p_pkg.sv =====
// ----------------------------------------------------------------------------
// mm2p_pkg
// Types, constants and the modular adder of the 2x2 matrix power block.
// ----------------------------------------------------------------------------
`default_nettype none

package mm2p_pkg;

    localparam int unsigned ENTRY_W      = 31;
    localparam int unsigned POWER_W      = 32;
    localparam int unsigned EXP_BITS_DEF = 32;
    localparam int unsigned IN_DATA_W    = 160;
    localparam int unsigned OUT_DATA_W   = 160;
    localparam int unsigned OUT_FIELDS_W = 5 * ENTRY_W;
    localparam logic [ENTRY_W-1:0] MOD_RESET = 31'd1234567891;

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef enum logic [1:0] {
        SRC_ONE,
        SRC_BASE,
        SRC_ACC
    } t_src;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_SAVE_PART,
        OP_WR_BASE,
        OP_WR_TMP,
        OP_COMMIT_ACC,
        OP_COMMIT_BASE,
        OP_SUM_CLR,
        OP_SUM_ADD,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op        op;
        t_src       a_src;
        logic [1:0] a_idx;
        logic [1:0] b_idx;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic exp_zero;
        logic exp_lsb;
        logic mod_small;
        logic out_free;
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RED,
        ST_RED_W,
        ST_CHECK,
        ST_M1,
        ST_M1_W,
        ST_M2,
        ST_M2_W,
        ST_COMMIT,
        ST_SUM,
        ST_FINISH
    } t_state;

    // (x + y) mod m for x and y already below m.
    function automatic t_entry add_mod(input t_entry x, input t_entry y, input t_entry m);
        logic [ENTRY_W:0] s;
        logic [ENTRY_W:0] d;
        begin
            s = {1'b0, x} + {1'b0, y};
            d = s - {1'b0, m};
            add_mod = (s >= {1'b0, m}) ? d[ENTRY_W-1:0] : s[ENTRY_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/mod_matrix2_power_core.sv =====
// ----------------------------------------------------------------------------
// mod_matrix2_power_core
// Modular 2x2 matrix power by square-and-multiply with a serial multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  s_axis    in         m00, m01, m10, m11, power
//  m_axis    out        p00, p01, p10, p11, entry_sum
//  cfg       in         modulus (write only)
//
//  One item at a time. Each modular product runs on a bit-serial multiplier
//  as a start, 31 bit steps and a write; a matrix product takes two per
//  entry. A modulus below two skips the computation and yields all zeros.
//  Reset is synchronous and active low; the modulus returns to 1234567891.
//  The result register lets the next word be accepted while one waits.
// ----------------------------------------------------------------------------
`default_nettype none

module mod_matrix2_power_core #(
    parameter int unsigned EXP_BITS = mm2p_pkg::EXP_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mm2p_pkg::ENTRY_W-1:0]    i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // m00, m01, m10, m11 (31 bits each), power (32 bits), zero pad
    input  wire logic [mm2p_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // p00, p01, p10, p11, entry_sum (31 bits each), zero pad
    output logic [mm2p_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import mm2p_pkg::*;

    t_cmd    cmd;
    t_status status;

    mm2p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mm2p_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_in_data   (s_axis_tdata),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== sv/mm2p_mulmod.sv =====
// ----------------------------------------------------------------------------
// mm2p_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2p_mulmod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mm2p_pkg::t_entry  i_a,
    input  wire mm2p_pkg::t_entry  i_b,
    input  wire mm2p_pkg::t_entry  i_mod,
    output logic                   o_busy,
    output mm2p_pkg::t_entry       o_result
);
    import mm2p_pkg::*;

    localparam int unsigned CNT_W = $clog2(ENTRY_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_entry           r_a;
    t_entry           r_b;
    t_entry           r_r;
    t_entry           n_r;

    // Horner step: r = 2r + bit * a, both terms kept below m. Requires a < m.
    always_comb begin
        n_r = add_mod(add_mod(r_r, r_r, i_mod), r_b[ENTRY_W-1] ? r_a : '0, i_mod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ENTRY_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            r_b <= {r_b[ENTRY_W-2:0], 1'b0};
        end
    end

    assign o_busy   = r_busy;
    assign o_result = r_r;

endmodule

`default_nettype wire

// ===== sv/mm2p_dp.sv =====
// ----------------------------------------------------------------------------
// mm2p_dp
// Datapath: matrix registers, exponent, modulus, sum and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2p_dp #(
    parameter int unsigned EXP_BITS = mm2p_pkg::EXP_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire mm2p_pkg::t_entry                 i_cfg_wdata,
    input  wire mm2p_pkg::t_cmd                   i_cmd,
    input  wire logic [mm2p_pkg::IN_DATA_W-1:0]   i_in_data,
    output mm2p_pkg::t_status                     o_status,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [mm2p_pkg::OUT_DATA_W-1:0]       o_out_data
);
    import mm2p_pkg::*;

    t_entry                  r_mod;
    t_entry                  r_base [4];
    t_entry                  r_acc  [4];
    t_entry                  r_tmp  [4];
    t_entry                  r_part;
    t_entry                  r_sum;
    logic [EXP_BITS-1:0]     r_exp;
    logic                    r_out_valid;
    logic [OUT_FIELDS_W-1:0] r_out;

    t_entry mul_a;
    t_entry mul_res;
    logic   mul_busy;
    logic   mod_small;

    assign mod_small = (r_mod < ENTRY_W'(2));

    always_comb begin
        case (i_cmd.a_src)
            SRC_BASE: mul_a = r_base[i_cmd.a_idx];
            SRC_ACC:  mul_a = r_acc[i_cmd.a_idx];
            default:  mul_a = ENTRY_W'(1);
        endcase
    end

    mm2p_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.op == OP_MUL),
        .i_a      (mul_a),
        .i_b      (r_base[i_cmd.b_idx]),
        .i_mod    (r_mod),
        .o_busy   (mul_busy),
        .o_result (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int i = 0; i < 4; i++) begin
                    r_base[i] <= i_in_data[i*ENTRY_W +: ENTRY_W];
                end
                r_acc[0] <= ENTRY_W'(1);
                r_acc[1] <= '0;
                r_acc[2] <= '0;
                r_acc[3] <= ENTRY_W'(1);
                r_exp    <= EXP_BITS'(i_in_data[4*ENTRY_W +: POWER_W]);
            end
            OP_SAVE_PART:   r_part <= mul_res;
            OP_WR_BASE:     r_base[i_cmd.k] <= mul_res;
            OP_WR_TMP:      r_tmp[i_cmd.k] <= add_mod(r_part, mul_res, r_mod);
            OP_COMMIT_ACC:  r_acc <= r_tmp;
            OP_COMMIT_BASE: begin
                r_base <= r_tmp;
                r_exp  <= r_exp >> 1;
            end
            OP_SUM_CLR:     r_sum <= '0;
            OP_SUM_ADD:     r_sum <= add_mod(r_sum, r_acc[i_cmd.k], r_mod);
            OP_FINISH: begin
                if (mod_small) begin
                    r_out <= '0;
                end else begin
                    r_out <= {r_sum, r_acc[3], r_acc[2], r_acc[1], r_acc[0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.mul_busy  = mul_busy;
    assign o_status.exp_zero  = (r_exp == '0);
    assign o_status.exp_lsb   = r_exp[0];
    assign o_status.mod_small = mod_small;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, r_out};

endmodule

`default_nettype wire

// ===== sv/mm2p_ctrl.sv =====
// ----------------------------------------------------------------------------
// mm2p_ctrl
// Sequencer for reduction, square-and-multiply steps and the final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2p_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mm2p_pkg::t_status i_status,
    output mm2p_pkg::t_cmd         o_cmd
);
    import mm2p_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_phase, n_phase;   // 0: acc = acc * base, 1: base = base * base

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_phase     = r_phase;
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NOP;
        o_cmd.a_src = r_phase ? SRC_BASE : SRC_ACC;
        o_cmd.a_idx = {r_k[1], 1'b0};
        o_cmd.b_idx = {1'b0, r_k[0]};
        o_cmd.k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_START;
                end
            end
            ST_START: begin
                n_k     = '0;
                n_state = i_status.mod_small ? ST_FINISH : ST_RED;
            end
            ST_RED: begin
                o_cmd.op    = OP_MUL;
                o_cmd.a_src = SRC_ONE;
                o_cmd.b_idx = r_k;
                n_state     = ST_RED_W;
            end
            ST_RED_W: begin
                if (!i_status.mul_busy) begin
                    o_cmd.op = OP_WR_BASE;
                    n_k      = r_k + 1'b1;
                    n_state  = (r_k == 2'd3) ? ST_CHECK : ST_RED;
                end
            end
            ST_CHECK: begin
                n_k = '0;
                if (i_status.exp_zero) begin
                    o_cmd.op = OP_SUM_CLR;
                    n_state  = ST_SUM;
                end else begin
                    n_phase = !i_status.exp_lsb;
                    n_state = ST_M1;
                end
            end
            ST_M1: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_M1_W;
            end
            ST_M1_W: begin
                if (!i_status.mul_busy) begin
                    o_cmd.op = OP_SAVE_PART;
                    n_state  = ST_M2;
                end
            end
            ST_M2: begin
                o_cmd.op    = OP_MUL;
                o_cmd.a_idx = {r_k[1], 1'b1};
                o_cmd.b_idx = {1'b1, r_k[0]};
                n_state     = ST_M2_W;
            end
            ST_M2_W: begin
                if (!i_status.mul_busy) begin
                    o_cmd.op = OP_WR_TMP;
                    n_k      = r_k + 1'b1;
                    n_state  = (r_k == 2'd3) ? ST_COMMIT : ST_M1;
                end
            end
            ST_COMMIT: begin
                n_k = '0;
                if (r_phase) begin
                    o_cmd.op = OP_COMMIT_BASE;
                    n_state  = ST_CHECK;
                end else begin
                    o_cmd.op = OP_COMMIT_ACC;
                    n_phase  = 1'b1;
                    n_state  = ST_M1;
                end
            end
            ST_SUM: begin
                o_cmd.op = OP_SUM_ADD;
                n_k      = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/mm2p_checker.sv =====
// ----------------------------------------------------------------------------
// mm2p_checker
// Port-level checks of the matrix power block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mod_matrix2_power_core_defines.svh"

module mm2p_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [159:0] m_axis_tdata
);

    // A stalled result word stays offered and unchanged.
    `MM2P_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // An accepted word keeps the input closed through ST_START and the ST_RED or ST_FINISH state that follows it.
    `MM2P_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready ##1 !s_axis_tready)

    // The pad bits above the five fields are always zero.
    `MM2P_ASSERT_NOW(a_out_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[159:155] == 5'd0)

    // The entry_sum field of a result is reduced, so it never holds all ones.
    `MM2P_ASSERT_NOW(a_out_reduced, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[154:124] != 31'h7FFFFFFF)

endmodule

bind mod_matrix2_power_core mm2p_checker u_mm2p_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
